// ----- rtl/core/strm_pkg.sv -----
// Package for the segment tree range-max core: state codes, field widths,
// register map and the empty-range constant. No dependencies.
`default_nettype none

package strm_pkg;

	localparam int unsigned IDX_W   = 10;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned LC_W    = 11;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned SDATA_W = 56;

	localparam logic [PADDR_W-1:0] REG_LEAF_COUNT = 3'd0;
	localparam logic [LC_W-1:0]    LEAF_COUNT_RST = 11'd1024;
	localparam logic signed [VAL_W-1:0] EMPTY_MAX = -32'sd1000000000;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_Q_LO,
		ST_Q_HI,
		ST_Q_FIN
	} strm_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/segment_tree_range_max_core.sv -----
// Segment tree range-max core: tree memory, walk sequencer, shared max unit.
// Depends on strm_pkg.
`default_nettype none

// Bottom-up segment tree of signed 32-bit values with max as the combine. After
// reset the tree memory is swept to zero, one entry a cycle, over all 2*MAX_LEAVES
// entries; s_tready stays low meanwhile (leaf_count writes are taken). An update
// (tuser op 0) writes the leaf and then, per ancestor level, does one memory read
// of the sibling and one write of the parent; an out-of-use update is dropped. A
// query (op 1) walks both range edges upward, up to log2(leaf_count)+1 levels, each
// level in the states ST_Q_LO and ST_Q_HI with at most one read each, and then
// passes through ST_Q_FIN; an empty or out-of-use range goes straight to ST_Q_FIN
// and returns EMPTY_MAX. Both walks are paced by the single read port of the tree
// memory and the one max unit. One request is worked at a time; a finished result
// waits in the output register while the next request is accepted.
module segment_tree_range_max_core
	import strm_pkg::*;
#(
	parameter int unsigned MAX_LEAVES = 1024
) (
	input  wire                 clk,
	input  wire                 arst_n,
	// APB register port
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire [PADDR_W-1:0]   paddr,
	input  wire [31:0]          pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// request stream
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire [SDATA_W-1:0]   s_tdata,  // first_index, last_index, new_value, pad
	input  wire [0:0]           s_tuser,  // op
	// result stream
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [VAL_W-1:0]    m_tdata   // max_value
);

	localparam int unsigned DEPTH = 2 * MAX_LEAVES;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned IW    = (AW + 1 > 12) ? AW + 1 : 12;

	strm_state_t state_q, state_d;

	logic [LC_W-1:0]          leaf_count_q;
	logic [AW-1:0]            clr_q, clr_d;
	logic [IW-1:0]            lo_q, lo_d, hi_q, hi_d;
	logic signed [VAL_W-1:0]  acc_q, acc_d;
	logic                     found_q, found_d;
	logic                     rd_pend_q, rd_issue;
	logic signed [VAL_W-1:0]  rd_data_q;
	logic                     m_tvalid_q, out_load;
	logic [VAL_W-1:0]         m_data_q;

	logic signed [VAL_W-1:0]  mem [DEPTH];
	logic                     mem_we;
	logic [AW-1:0]            mem_waddr, mem_raddr;
	logic signed [VAL_W-1:0]  mem_wdata;

	logic                     in_op;
	logic [IW-1:0]            first_ext, last_ext, lc_ext, n_used;
	logic [IW-1:0]            leaf_node, hi_start, sib_node, par_node, hi_m1;
	logic signed [VAL_W-1:0]  in_value, cmb_max;
	logic                     cfg_wr;

	assign in_op     = s_tuser[0];
	assign first_ext = IW'(s_tdata[IDX_W-1:0]);
	assign last_ext  = IW'(s_tdata[2*IDX_W-1:IDX_W]);
	assign in_value  = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

	assign lc_ext    = IW'(leaf_count_q);
	assign n_used    = (lc_ext > IW'(MAX_LEAVES)) ? IW'(MAX_LEAVES) : lc_ext;
	assign leaf_node = first_ext + n_used;
	assign hi_start  = last_ext + n_used + IW'(1);
	assign sib_node  = lo_q ^ IW'(1);
	assign par_node  = lo_q >> 1;
	assign hi_m1     = hi_q - IW'(1);

	// shared max unit: folds the registered memory word into the accumulator
	assign cmb_max = (!found_q || (rd_data_q > acc_q)) ? rd_data_q : acc_q;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[PADDR_W-1] == REG_LEAF_COUNT[PADDR_W-1]) ?
		32'(leaf_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_count_q <= LEAF_COUNT_RST;
		end else if (cfg_wr && (paddr[PADDR_W-1] == REG_LEAF_COUNT[PADDR_W-1])) begin
			leaf_count_q <= pwdata[LC_W-1:0];
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		acc_d     = rd_pend_q ? cmb_max : acc_q;
		found_d   = found_q | rd_pend_q;
		rd_issue  = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = cmb_max;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end else begin
					clr_d = clr_q + AW'(1);
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					if (in_op == OP_UPDATE) begin
						if (first_ext < n_used) begin
							mem_we    = 1'b1;
							mem_waddr = leaf_node[AW-1:0];
							mem_wdata = in_value;
							lo_d      = leaf_node;
							acc_d     = in_value;
							found_d   = 1'b1;
							state_d   = ST_UPD_RD;
						end
					end else if (first_ext > last_ext || first_ext >= n_used ||
							last_ext >= n_used) begin
						acc_d   = EMPTY_MAX;
						state_d = ST_Q_FIN;
					end else begin
						lo_d    = leaf_node;
						hi_d    = hi_start;
						acc_d   = EMPTY_MAX;
						found_d = 1'b0;
						state_d = ST_Q_LO;
					end
				end
			end
			ST_UPD_RD: begin
				if (lo_q > IW'(1)) begin
					rd_issue  = 1'b1;
					mem_raddr = sib_node[AW-1:0];
					state_d   = ST_UPD_WR;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_UPD_WR: begin
				mem_we    = 1'b1;
				mem_waddr = par_node[AW-1:0];
				mem_wdata = cmb_max;
				lo_d      = par_node;
				state_d   = ST_UPD_RD;
			end
			ST_Q_LO: begin
				if (lo_q < hi_q) begin
					if (lo_q[0]) begin
						rd_issue  = 1'b1;
						mem_raddr = lo_q[AW-1:0];
						lo_d      = lo_q + IW'(1);
					end
					state_d = ST_Q_HI;
				end else begin
					state_d = ST_Q_FIN;
				end
			end
			ST_Q_HI: begin
				if (hi_q[0]) begin
					rd_issue  = 1'b1;
					mem_raddr = hi_m1[AW-1:0];
				end
				hi_d    = hi_q >> 1;
				lo_d    = lo_q >> 1;
				state_d = ST_Q_LO;
			end
			ST_Q_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			rd_pend_q  <= 1'b0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_q     <= clr_d;
			rd_pend_q <= rd_issue;
			found_q   <= found_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		acc_q <= acc_d;
		if (out_load) begin
			m_data_q <= acc_q;
		end
	end

	// tree memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

`ifndef SYNTHESIS
	a_parent_needs_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD_WR) |-> rd_pend_q)
		else $error("parent write without sibling read");

	a_pend_source: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> ($past(state_q) == ST_UPD_RD || $past(state_q) == ST_Q_LO ||
			$past(state_q) == ST_Q_HI))
		else $error("read pending from wrong state");

	a_query_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_LO || state_q == ST_Q_HI || state_q == ST_Q_FIN) |-> !mem_we)
		else $error("tree written during query");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_Q_FIN)
		else $error("result not from query finish");

	a_fin_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_FIN) |-> !rd_pend_q)
		else $error("query finished with read outstanding");
`endif

endmodule

`default_nettype wire
